// File: rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the text console writer.
// Depends on nothing; every other file of the block imports it.
package tcw_pkg;

	// Screen geometry.
	localparam int NUM_COLUMNS = 80;
	localparam int NUM_ROWS    = 25;
	localparam int CELL_COUNT  = NUM_COLUMNS * NUM_ROWS;
	localparam int CELL_AW     = $clog2(CELL_COUNT);

	// Field widths of the item and result channels.
	localparam int CMD_W     = 2;
	localparam int CHAR_W    = 8;
	localparam int ATTR_W    = 8;
	localparam int IDX_W     = 11;
	localparam int COL_W     = 7;
	localparam int ROW_W     = 5;
	localparam int CURSOR_AW = 11;
	localparam int CELL_W    = CHAR_W + ATTR_W;

	// Character codes and attributes.
	localparam logic [CHAR_W-1:0] BLANK_CHAR      = 8'h20;
	localparam logic [CHAR_W-1:0] LINE_FEED       = 8'h0a;
	localparam logic [CHAR_W-1:0] CARRIAGE_RETURN = 8'h0d;
	localparam logic [CHAR_W-1:0] PRINT_LO        = 8'h20;
	localparam logic [CHAR_W-1:0] PRINT_HI        = 8'h7e;
	localparam logic [ATTR_W-1:0] RESET_ATTR      = 8'h07;

	typedef enum logic [CMD_W-1:0] {
		CMD_SHOW  = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OP_IDLE,
		ST_OP_WRITE,
		ST_OP_READ,
		ST_OP_FILL,
		ST_OP_SCROLL
	} store_op_t;

	typedef struct packed {
		store_op_t           op;
		logic [CELL_AW-1:0]  addr;
		logic [CELL_W-1:0]   data;
	} store_req_t;

	typedef struct packed {
		logic                done;
		logic [CELL_W-1:0]   rdata;
	} store_rsp_t;

	typedef struct packed {
		logic [COL_W-1:0]     col;
		logic [ROW_W-1:0]     row;
		logic [CURSOR_AW-1:0] addr;
		logic                 scrolled;
		logic [CHAR_W-1:0]    cell_char;
		logic [ATTR_W-1:0]    cell_attr;
	} result_t;

	typedef enum logic [2:0] {
		SEQ_INIT,
		SEQ_INIT_WAIT,
		SEQ_IDLE,
		SEQ_WAIT,
		SEQ_FIN
	} seq_state_t;

	// A cell holds the character in the low byte and the attribute in the high byte.
	function automatic logic [CELL_W-1:0] make_cell(logic [CHAR_W-1:0] c,
		logic [ATTR_W-1:0] a);
		return {a, c};
	endfunction

endpackage

// File: rtl/core/tcw_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the text console writer.
// Depends on tcw_pkg for the field widths.
interface tcw_cmd_if;
	import tcw_pkg::*;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [CHAR_W-1:0] ch;
	logic [ATTR_W-1:0] attr;
	logic [IDX_W-1:0]  cell_index;

	modport source (output valid, cmd, ch, attr, cell_index, input ready);
	modport sink (input valid, cmd, ch, attr, cell_index, output ready);
endinterface

interface tcw_res_if;
	import tcw_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [COL_W-1:0]     cursor_column;
	logic [ROW_W-1:0]     cursor_row;
	logic [CURSOR_AW-1:0] cursor_offset;
	logic                 scrolled;
	logic [CHAR_W-1:0]    cell_char;
	logic [ATTR_W-1:0]    cell_attr;

	modport source (output valid, cursor_column, cursor_row, cursor_offset, scrolled,
		cell_char, cell_attr, input ready);
	modport sink (input valid, cursor_column, cursor_row, cursor_offset, scrolled,
		cell_char, cell_attr, output ready);
endinterface

// File: rtl/core/tcw_store.sv
`timescale 1ns / 1ps
// Screen cell memory with its sweep unit: one address counter and one adder
// walk the cells for fill and scroll. Depends on tcw_pkg.
module tcw_store (
	input  logic                clk,
	input  logic                arst_n,
	input  tcw_pkg::store_req_t req,
	output tcw_pkg::store_rsp_t rsp
);
	import tcw_pkg::*;

	localparam int COPY_END = CELL_COUNT - NUM_COLUMNS;

	logic [CELL_W-1:0]  mem [CELL_COUNT];

	logic               sweep_q;
	logic               scroll_q;
	logic [CELL_AW-1:0] idx_q;
	logic [CELL_W-1:0]  fill_q;
	logic               done_q;
	logic [CELL_W-1:0]  rdata_q;

	logic               wr_s1;
	logic               copy_s1;
	logic [CELL_AW-1:0] waddr_s1;

	logic [CELL_AW-1:0] src_sum;
	logic               copy_now;
	logic               last_idx;
	logic               start;
	logic               we;
	logic [CELL_AW-1:0] waddr;
	logic [CELL_AW-1:0] raddr;
	logic [CELL_W-1:0]  wdata;

	// A scroll reads the cell one row below and writes it in the next cycle.
	// The source index stays below CELL_COUNT while copying, so it never overflows while it is used.
	assign src_sum  = idx_q + CELL_AW'(NUM_COLUMNS);
	assign copy_now = scroll_q && (idx_q < CELL_AW'(COPY_END));
	assign last_idx = (idx_q == CELL_AW'(CELL_COUNT - 1));
	assign start    = !sweep_q && (req.op == ST_OP_FILL || req.op == ST_OP_SCROLL);

	always_comb begin
		if (sweep_q) begin
			raddr = copy_now ? src_sum : '0;
		end else begin
			raddr = req.addr;
		end
		if (wr_s1) begin
			we    = 1'b1;
			waddr = waddr_s1;
			wdata = copy_s1 ? rdata_q : fill_q;
		end else if (req.op == ST_OP_WRITE) begin
			we    = 1'b1;
			waddr = req.addr;
			wdata = req.data;
		end else begin
			we    = 1'b0;
			waddr = req.addr;
			wdata = req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q  <= 1'b0;
			scroll_q <= 1'b0;
			idx_q    <= '0;
			wr_s1    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			wr_s1  <= sweep_q;
			done_q <= (wr_s1 && waddr_s1 == CELL_AW'(CELL_COUNT - 1))
				|| req.op == ST_OP_READ || req.op == ST_OP_WRITE;
			if (sweep_q) begin
				idx_q <= idx_q + 1'b1;
				if (last_idx) begin
					sweep_q <= 1'b0;
				end
			end else if (start) begin
				sweep_q  <= 1'b1;
				scroll_q <= (req.op == ST_OP_SCROLL);
				idx_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= idx_q;
		copy_s1  <= copy_now;
		if (start) begin
			fill_q <= req.data;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rsp.done  = done_q;
	assign rsp.rdata = rdata_q;

endmodule

// File: rtl/core/tcw_seq.sv
`timescale 1ns / 1ps
// Sequencer of the text console writer: cursor state, command decode and
// the order of memory operations. Depends on tcw_pkg and tcw_if.
module tcw_seq (
	input  logic                    clk,
	input  logic                    arst_n,
	tcw_cmd_if.sink                 item,
	input  logic [tcw_pkg::ATTR_W-1:0] default_attr,
	output tcw_pkg::store_req_t     store_req,
	input  tcw_pkg::store_rsp_t     store_rsp,
	output logic                    res_valid,
	input  logic                    res_ready,
	output tcw_pkg::result_t        res
);
	import tcw_pkg::*;

	seq_state_t        state_q, state_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [ATTR_W-1:0] cur_attr_q, cur_attr_d;
	logic              scrolled_q, scrolled_d;
	logic              pend_scroll_q, pend_scroll_d;
	logic              is_read_q, is_read_d;
	logic [CHAR_W-1:0] rc_q, rc_d;
	logic [ATTR_W-1:0] ra_q, ra_d;

	logic              col_last;
	logic              row_last;
	logic [CELL_AW-1:0] pos;

	assign col_last = (col_q == COL_W'(NUM_COLUMNS - 1));
	assign row_last = (row_q == ROW_W'(NUM_ROWS - 1));
	assign pos      = CELL_AW'(int'(col_q) + int'(row_q) * NUM_COLUMNS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= SEQ_INIT;
			col_q         <= '0;
			row_q         <= '0;
			cur_attr_q    <= RESET_ATTR;
			pend_scroll_q <= 1'b0;
			is_read_q     <= 1'b0;
		end else begin
			state_q       <= state_d;
			col_q         <= col_d;
			row_q         <= row_d;
			cur_attr_q    <= cur_attr_d;
			pend_scroll_q <= pend_scroll_d;
			is_read_q     <= is_read_d;
		end
	end

	always_ff @(posedge clk) begin
		scrolled_q <= scrolled_d;
		rc_q       <= rc_d;
		ra_q       <= ra_d;
	end

	always_comb begin
		state_d       = state_q;
		col_d         = col_q;
		row_d         = row_q;
		cur_attr_d    = cur_attr_q;
		scrolled_d    = scrolled_q;
		pend_scroll_d = pend_scroll_q;
		is_read_d     = is_read_q;
		rc_d          = rc_q;
		ra_d          = ra_q;
		store_req     = '{op: ST_OP_IDLE, addr: '0, data: '0};
		item.ready    = 1'b0;
		res_valid     = 1'b0;

		case (state_q)
			SEQ_INIT: begin
				store_req.op   = ST_OP_FILL;
				store_req.data = make_cell(BLANK_CHAR, RESET_ATTR);
				state_d        = SEQ_INIT_WAIT;
			end
			SEQ_INIT_WAIT: begin
				if (store_rsp.done) begin
					state_d = SEQ_IDLE;
				end
			end
			SEQ_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					scrolled_d    = 1'b0;
					pend_scroll_d = 1'b0;
					is_read_d     = 1'b0;
					rc_d          = '0;
					ra_d          = '0;
					state_d       = SEQ_FIN;
					case (cmd_t'(item.cmd))
						CMD_SHOW: begin
							if (item.ch == LINE_FEED) begin
								col_d = '0;
								if (row_last) begin
									store_req.op   = ST_OP_SCROLL;
									store_req.data = make_cell(BLANK_CHAR, cur_attr_q);
									scrolled_d     = 1'b1;
									state_d        = SEQ_WAIT;
								end else begin
									row_d = row_q + 1'b1;
								end
							end else if (item.ch == CARRIAGE_RETURN) begin
								col_d = '0;
							end else if (item.ch inside {[PRINT_LO:PRINT_HI]}) begin
								cur_attr_d     = item.attr;
								store_req.op   = ST_OP_WRITE;
								store_req.addr = pos;
								store_req.data = make_cell(item.ch, item.attr);
								state_d        = SEQ_WAIT;
								if (col_last) begin
									col_d = '0;
									if (row_last) begin
										// The scroll follows once the cell write is done.
										pend_scroll_d = 1'b1;
										scrolled_d    = 1'b1;
									end else begin
										row_d = row_q + 1'b1;
									end
								end else begin
									col_d = col_q + 1'b1;
								end
							end
						end
						CMD_CLEAR: begin
							store_req.op   = ST_OP_FILL;
							store_req.data = make_cell(BLANK_CHAR, default_attr);
							col_d          = '0;
							row_d          = '0;
							state_d        = SEQ_WAIT;
						end
						CMD_READ: begin
							if (item.cell_index < IDX_W'(CELL_COUNT)) begin
								store_req.op   = ST_OP_READ;
								store_req.addr = item.cell_index[CELL_AW-1:0];
								is_read_d      = 1'b1;
								state_d        = SEQ_WAIT;
							end
						end
						default: begin
						end
					endcase
				end
			end
			SEQ_WAIT: begin
				if (store_rsp.done) begin
					if (is_read_q) begin
						rc_d = store_rsp.rdata[CHAR_W-1:0];
						ra_d = store_rsp.rdata[CELL_W-1:CHAR_W];
					end
					if (pend_scroll_q) begin
						store_req.op   = ST_OP_SCROLL;
						store_req.data = make_cell(BLANK_CHAR, cur_attr_q);
						pend_scroll_d  = 1'b0;
					end else begin
						state_d = SEQ_FIN;
					end
				end
			end
			SEQ_FIN: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = SEQ_IDLE;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	assign res.col       = col_q;
	assign res.row       = row_q;
	assign res.addr      = CURSOR_AW'(int'(col_q) + int'(row_q) * NUM_COLUMNS);
	assign res.scrolled  = scrolled_q;
	assign res.cell_char = rc_q;
	assign res.cell_attr = ra_q;

endmodule

// File: rtl/core/text_console_writer.sv
`timescale 1ns / 1ps
// Text console writer top level: holds the default attribute register and the result register.
// With the output free, a cursor-only item, an unused command or a read past the end goes from
// SEQ_IDLE via SEQ_FIN to the output register; a printable character or a cell read first waits
// in SEQ_WAIT for the store, a scrolling line feed or a clear for a sweep of all cells, a wrap
// that scrolls for its write and then the sweep. One item at a time, taken once the last result
// is registered. Reset is asynchronous; after it a clearing pass holds the input off.
module text_console_writer (
	input  logic                       clk,
	input  logic                       arst_n,
	tcw_cmd_if.sink                    item,
	tcw_res_if.source                  result,
	input  logic                       cfg_we,
	input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata
);
	import tcw_pkg::*;

	// Clear command attribute. Users write it only while the block is idle; it is not enforced.
	logic [ATTR_W-1:0] default_attr_q;

	// Request and response between the sequencer and the cell store.
	store_req_t store_req;
	store_rsp_t store_rsp;

	// Finished result handed from the sequencer to the output register.
	result_t    res;
	logic       res_valid;
	logic       res_ready;
	logic       load;

	// The output register.
	logic       out_valid_q;
	result_t    out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_attr_q <= RESET_ATTR;
		end else if (cfg_we) begin
			default_attr_q <= cfg_wdata;
		end
	end

	// The sequencer decodes each item, moves the cursor and issues cell writes, reads,
	// fills and scrolls to the store.
	tcw_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.default_attr (default_attr_q),
		.store_req    (store_req),
		.store_rsp    (store_rsp),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	// The store walks all cells one per cycle for fills and scrolls.
	tcw_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (store_req),
		.rsp    (store_rsp)
	);

	// A new result may enter the output register when it is empty or its transfer
	// completes in this cycle.
	assign res_ready = !out_valid_q || result.ready;
	assign load      = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.cursor_column = out_q.col;
	assign result.cursor_row    = out_q.row;
	assign result.cursor_offset = out_q.addr;
	assign result.scrolled      = out_q.scrolled;
	assign result.cell_char     = out_q.cell_char;
	assign result.cell_attr     = out_q.cell_attr;

	// The sequencer is busy in the cycle after every item transfer.
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("item accepted on two consecutive cycles");

	// Every scroll leaves the cursor at the start of the last row.
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.scrolled |->
			result.cursor_row == ROW_W'(NUM_ROWS - 1) && result.cursor_column == '0)
		else $error("scroll left the cursor off the start of the last row");

	// Only a read returns cell contents, and a read never scrolls.
	a_scroll_no_cell: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.scrolled |-> result.cell_char == '0 && result.cell_attr == '0)
		else $error("scrolling result carries cell contents");

endmodule

// File: bench/tb_text_console_writer.sv
`timescale 1ns / 1ps
// Self-checking testbench of text_console_writer: drives items, predicts each cursor report
// and compares it with the block's result. Depends on tcw_pkg and the tcw_cmd_if/tcw_res_if
// channel interfaces.
module tb_text_console_writer;
	import tcw_pkg::*;

	// Cycles without any transfer before the run is declared hung. The slowest legal gap is
	// the clearing pass after reset or a scroll sweep, or the receiver hold-off below; the
	// limit is several times the worst of these.
	localparam int STALL_LIMIT     = 20000;
	localparam int IDLE_PERCENT    = 28;
	localparam int MAX_REPORTS     = 10;
	localparam int DRAIN_CYCLES    = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_PHASES   = 6;
	localparam int PHASE_ITEMS     = 100;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [ATTR_W-1:0] cfg_wdata;

	tcw_cmd_if item_ch ();
	tcw_res_if res_ch ();

	text_console_writer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Predicted console state: the screen image, the cursor, the attribute of the last
	// printed character (which also fills rows uncovered by a scroll) and the attribute
	// that a clear uses.
	logic [CELL_W-1:0] screen_image [CELL_COUNT];
	int                cursor_col;
	int                cursor_row;
	logic [ATTR_W-1:0] text_attr;
	logic [ATTR_W-1:0] clear_attr;

	// Cursor reports predicted for accepted items, oldest first.
	result_t pending_reports [$];

	int mismatch_count = 0;
	bit traffic_gaps   = 1'b1;
	int hold_off_left  = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Console predictor
	// ------------------------------------------------------------------

	function automatic void blank_screen(logic [ATTR_W-1:0] a);
		for (int i = 0; i < CELL_COUNT; i++)
			screen_image[i] = {a, BLANK_CHAR};
	endfunction

	// Moves the cursor to the start of the next row. On the last row the whole image moves
	// up one row and the freed bottom row is blanked with the current text attribute.
	// Returns 1 when that scroll happened.
	function automatic bit feed_line();
		cursor_col = 0;
		if (cursor_row + 1 < NUM_ROWS) begin
			cursor_row++;
			return 1'b0;
		end
		for (int i = 0; i < CELL_COUNT - NUM_COLUMNS; i++)
			screen_image[i] = screen_image[i + NUM_COLUMNS];
		for (int i = CELL_COUNT - NUM_COLUMNS; i < CELL_COUNT; i++)
			screen_image[i] = {text_attr, BLANK_CHAR};
		cursor_row = NUM_ROWS - 1;
		return 1'b1;
	endfunction

	// Applies one item to the predicted state and returns the report the block owes for it.
	function automatic result_t next_console_result(cmd_t op, logic [CHAR_W-1:0] c,
		logic [ATTR_W-1:0] a, logic [IDX_W-1:0] idx);
		result_t r;
		r = '0;
		case (op)
			CMD_SHOW: begin
				if (c == LINE_FEED) begin
					r.scrolled = feed_line();
				end else if (c == CARRIAGE_RETURN) begin
					cursor_col = 0;
				end else if (c >= PRINT_LO && c <= PRINT_HI) begin
					text_attr = a;
					screen_image[cursor_col + cursor_row * NUM_COLUMNS] = {a, c};
					if (cursor_col + 1 < NUM_COLUMNS)
						cursor_col++;
					else
						r.scrolled = feed_line();
				end
				// Every other code leaves the console untouched.
			end
			CMD_CLEAR: begin
				// The clear uses the register value; the text attribute is kept.
				blank_screen(clear_attr);
				cursor_col = 0;
				cursor_row = 0;
			end
			CMD_READ: begin
				// Reads past the end of the screen return zero for both bytes.
				if (idx < CELL_COUNT)
					{r.cell_attr, r.cell_char} = screen_image[idx];
			end
			default: begin
			end
		endcase
		r.col  = COL_W'(cursor_col);
		r.row  = ROW_W'(cursor_row);
		r.addr = CURSOR_AW'(cursor_col + cursor_row * NUM_COLUMNS);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Sending side
	// ------------------------------------------------------------------

	// Offers one item and returns at the clock edge where it transfers. Valid stays high on
	// return so that back-to-back items follow without a gap; a random gap lowers it first.
	task automatic send_item(cmd_t op, logic [CHAR_W-1:0] c, logic [ATTR_W-1:0] a,
		logic [IDX_W-1:0] idx);
		if (traffic_gaps && $urandom_range(99) < IDLE_PERCENT) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.cmd        <= op;
		item_ch.ch         <= c;
		item_ch.attr       <= a;
		item_ch.cell_index <= idx;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		pending_reports.push_back(next_console_result(op, c, a, idx));
	endtask

	// Mostly text with short lines, plus reads near the cursor so that freshly written
	// cells get read back. Clears are rare, since each one sweeps the whole screen.
	task automatic send_random_item();
		int                pick;
		int                here;
		int                back;
		logic [CHAR_W-1:0] c;
		logic [ATTR_W-1:0] a;
		logic [IDX_W-1:0]  idx;
		pick = $urandom_range(999);
		c    = CHAR_W'($urandom_range(255));
		a    = ATTR_W'($urandom_range(255));
		idx  = IDX_W'($urandom_range(2047));
		if (pick < 60) begin
			send_item(CMD_SHOW, LINE_FEED, a, idx);
		end else if (pick < 100) begin
			send_item(CMD_SHOW, CARRIAGE_RETURN, a, idx);
		end else if (pick < 160) begin
			// Control codes, delete and the upper half of the byte range are ignored.
			while ((c >= PRINT_LO && c <= PRINT_HI) || c == LINE_FEED || c == CARRIAGE_RETURN)
				c = CHAR_W'($urandom_range(255));
			send_item(CMD_SHOW, c, a, idx);
		end else if (pick < 390) begin
			if (pick < 275) begin
				here = cursor_col + cursor_row * NUM_COLUMNS;
				back = $urandom_range(0, 160);
				idx  = (here > back) ? IDX_W'(here - back) : '0;
			end
			send_item(CMD_READ, c, a, idx);
		end else if (pick < 405) begin
			send_item(CMD_NONE, c, a, idx);
		end else if (pick < 410) begin
			send_item(CMD_CLEAR, c, a, idx);
		end else begin
			send_item(CMD_SHOW, CHAR_W'($urandom_range(PRINT_LO, PRINT_HI)), a, idx);
		end
	endtask

	// Lowers valid and waits until every predicted report has come back. The loop always
	// waits on a clock edge first, so a following item never re-raises valid in the same step.
	task automatic wait_for_drain();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_reports.size() != 0);
	endtask

	// Register writes happen only with the block idle.
	task automatic set_default_attribute(logic [ATTR_W-1:0] v);
		wait_for_drain();
		cfg_we     <= 1'b1;
		cfg_wdata  <= v;
		clear_attr = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Receiving side and checking
	// ------------------------------------------------------------------

	// Result ready: a counted hold-off when a test asks for one, random stalls with gaps on.
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_left > 0) begin
				hold_off_left--;
				res_ch.ready <= 1'b0;
			end else if (traffic_gaps && $urandom_range(99) < IDLE_PERCENT) begin
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Every result transfer is matched against the oldest pending prediction.
	always @(posedge clk) begin
		result_t seen;
		result_t want;
		if (res_ch.valid && res_ch.ready) begin
			seen.col       = res_ch.cursor_column;
			seen.row       = res_ch.cursor_row;
			seen.addr      = res_ch.cursor_offset;
			seen.scrolled  = res_ch.scrolled;
			seen.cell_char = res_ch.cell_char;
			seen.cell_attr = res_ch.cell_attr;
			if (pending_reports.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: result transfer with no item outstanding", $realtime);
			end else begin
				want = pending_reports.pop_front();
				if (seen !== want) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$write("%0t: bad report col/row/addr/scrolled/char/attr ", $realtime);
						$display("got %0d %0d %0d %0b %02h %02h, want %0d %0d %0d %0b %02h %02h",
							seen.col, seen.row, seen.addr, seen.scrolled,
							seen.cell_char, seen.cell_attr, want.col, want.row, want.addr,
							want.scrolled, want.cell_char, want.cell_attr);
					end
				end
			end
		end
	end

	// Watchdog: counts edges at which neither channel transfers.
	initial begin
		int stalled_cycles;
		stalled_cycles = 0;
		while (stalled_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
				stalled_cycles = 0;
			else
				stalled_cycles++;
		end
		$display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// After reset every cell is a space in attribute 7. Covers the first and last cell,
	// reads past the end of the screen and the unused command.
	task automatic test_reset_state();
		send_item(CMD_READ, 8'hff, 8'hff, '0);
		send_item(CMD_READ, 8'h00, 8'h00, IDX_W'(CELL_COUNT - 1));
		send_item(CMD_READ, 8'h5a, 8'ha5, IDX_W'(CELL_COUNT));
		send_item(CMD_READ, 8'h00, 8'h00, '1);
		send_item(CMD_NONE, CHAR_W'($urandom_range(255)), ATTR_W'($urandom_range(255)),
			IDX_W'($urandom_range(2047)));
	endtask

	// Edges of the printable range, codes just outside it, carriage return and line feed.
	task automatic test_show_codes();
		send_item(CMD_SHOW, PRINT_LO, 8'h00, '1);
		send_item(CMD_SHOW, PRINT_HI, 8'hff, '0);
		send_item(CMD_SHOW, 8'h1f, 8'h12, '0);
		send_item(CMD_SHOW, 8'h7f, 8'h34, '0);
		send_item(CMD_SHOW, 8'hff, 8'h56, '1);
		send_item(CMD_SHOW, 8'h00, 8'h78, '0);
		send_item(CMD_READ, 8'h00, 8'h00, IDX_W'(0));
		send_item(CMD_READ, 8'h00, 8'h00, IDX_W'(1));
		send_item(CMD_SHOW, CARRIAGE_RETURN, 8'h9a, '0);
		send_item(CMD_SHOW, LINE_FEED, 8'hbc, '0);
		send_item(CMD_SHOW, 8'h41, 8'h5a, '0);
		send_item(CMD_READ, 8'h00, 8'h00, IDX_W'(NUM_COLUMNS));
	endtask

	// A clear blanks with the register value (all ones here) but must keep the attribute
	// of the last printed character; the scroll test checks that later.
	task automatic test_clear();
		send_item(CMD_SHOW, 8'h2a, 8'h3c, '0);
		send_item(CMD_CLEAR, 8'h41, 8'hff, '1);
		send_item(CMD_READ, 8'h00, 8'h00, IDX_W'(0));
		send_item(CMD_READ, 8'h00, 8'h00, IDX_W'(CELL_COUNT - 1));
	endtask

	task automatic test_wrap_and_scroll();
		int n;
		// Line feeds alone walk the cursor down; the one on the last row scrolls, and the
		// new bottom row must carry the text attribute from before the clear.
		for (int i = 0; i < NUM_ROWS; i++)
			send_item(CMD_SHOW, LINE_FEED, ATTR_W'($urandom_range(255)), '0);
		send_item(CMD_READ, 8'h00, 8'h00,
			IDX_W'((NUM_ROWS - 1) * NUM_COLUMNS + $urandom_range(NUM_COLUMNS - 1)));
		send_item(CMD_READ, 8'h00, 8'h00, IDX_W'(0));
		// A full line on the last row wraps and scrolls at the last column.
		for (int i = 0; i < NUM_COLUMNS; i++)
			send_item(CMD_SHOW, CHAR_W'($urandom_range(PRINT_LO, PRINT_HI)),
				ATTR_W'($urandom_range(255)), '0);
		for (int i = 0; i < 6; i++)
			send_item(CMD_READ, 8'h00, 8'h00,
				IDX_W'($urandom_range((NUM_ROWS - 2) * NUM_COLUMNS, CELL_COUNT - 1)));
		send_item(CMD_SHOW, CARRIAGE_RETURN, 8'h00, '0);
		// From a clean screen, lines of random length (some longer than a row) until the
		// cursor sits on the last row, then a few more so that text scrolls off the top.
		send_item(CMD_CLEAR, 8'h00, 8'h00, '0);
		while (cursor_row < NUM_ROWS - 1) begin
			n = $urandom_range(0, 100);
			for (int i = 0; i < n; i++)
				send_item(CMD_SHOW, CHAR_W'($urandom_range(PRINT_LO, PRINT_HI)),
					ATTR_W'($urandom_range(255)), '0);
			send_item(CMD_SHOW, LINE_FEED, 8'h00, '0);
		end
		for (int k = 0; k < 3; k++) begin
			n = $urandom_range(0, 40);
			for (int i = 0; i < n; i++)
				send_item(CMD_SHOW, CHAR_W'($urandom_range(PRINT_LO, PRINT_HI)),
					ATTR_W'($urandom_range(255)), '0);
			send_item(CMD_SHOW, LINE_FEED, 8'h00, '0);
			send_item(CMD_READ, 8'h00, 8'h00, IDX_W'($urandom_range(CELL_COUNT - 1)));
		end
	endtask

	// The receiver stops for a long stretch while items keep coming, so the output register
	// fills and the block has to hold its input off.
	task automatic test_backpressure();
		traffic_gaps  = 1'b0;
		hold_off_left = HOLD_OFF_CYCLES;
		repeat (16) send_random_item();
		traffic_gaps = 1'b1;
	endtask

	// Random traffic under several register values; one phase runs with no idling at all.
	task automatic test_random_traffic();
		logic [ATTR_W-1:0] attr_value;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 0)
				attr_value = 8'h80;
			else if (phase == RANDOM_PHASES - 1)
				attr_value = RESET_ATTR;
			else
				attr_value = ATTR_W'($urandom_range(255));
			set_default_attribute(attr_value);
			traffic_gaps = (phase != 2);
			repeat (PHASE_ITEMS) send_random_item();
		end
		traffic_gaps = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= '0;
		item_ch.valid      <= 1'b0;
		item_ch.cmd        <= CMD_SHOW;
		item_ch.ch         <= '0;
		item_ch.attr       <= '0;
		item_ch.cell_index <= '0;
		clear_attr = RESET_ATTR;
		text_attr  = RESET_ATTR;
		cursor_col = 0;
		cursor_row = 0;
		blank_screen(RESET_ATTR);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// The first items wait out the clearing pass through the handshake.
		test_reset_state();
		test_show_codes();
		set_default_attribute(8'hff);
		test_clear();
		set_default_attribute(8'h00);
		test_wrap_and_scroll();
		test_backpressure();
		test_random_traffic();

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_reports.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: files.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_if.sv
rtl/core/tcw_store.sv
rtl/core/tcw_seq.sv
rtl/core/text_console_writer.sv
bench/tb_text_console_writer.sv
